### hw/rtl/trilinear_table_interpolator_core_defines.svh
// ----------------------------------------------------------------------------
// Trilinear table interpolator assertion macros
// Property wrappers clocked on clk_i with reset rst_ni; empty when
// ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef TRILINEAR_TABLE_INTERPOLATOR_CORE_DEFINES_SVH
`define TRILINEAR_TABLE_INTERPOLATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define TTI_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TTI_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define TTI_ASSERT(name, prop, msg)
`define TTI_ASSERT_NEVER(name, cond, msg)
`endif

`endif

### hw/rtl/tti_pkg.sv
// ----------------------------------------------------------------------------
// Trilinear table interpolator package
// Shared widths, codes, the controller/datapath command structs, the
// micro-op table of the coefficient multiply chain and a 48-bit saturation.
// ----------------------------------------------------------------------------
package tti_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OUT_W       = 48;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned STORE_AW    = 12;
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned IN_TDATA_W  = 144;
  localparam int unsigned OUT_TDATA_W = 192;
  localparam int unsigned COEF_W      = 36;
  localparam int unsigned MOP_W       = 42;
  localparam int unsigned FRAC_W      = 17;
  localparam int unsigned ACC_W       = 60;
  localparam int unsigned N_UOP       = 17;
  localparam int unsigned UOP_IDX_W   = 5;
  localparam int unsigned N_WREG      = 10;

  localparam logic [DATA_W-1:0] INV_STEP_RESET = 32'h0001_0000;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_X_OUT = 2'd1,
    ST_Y_OUT = 2'd2,
    ST_Z_OUT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_ORIGIN_Z   = 3'd2,
    CFG_INV_STEP_X = 3'd3,
    CFG_INV_STEP_Y = 3'd4,
    CFG_INV_STEP_Z = 3'd5
  } cfg_e;

  // Working registers of the multiply chain.
  typedef enum logic [3:0] {
    W_GXY = 4'd0,
    W_TYB = 4'd1,
    W_GX  = 4'd2,
    W_GY  = 4'd3,
    W_GZ  = 4'd4,
    W_TZ  = 4'd5,
    W_VAL = 4'd6,
    W_SX  = 4'd7,
    W_SY  = 4'd8,
    W_SZ  = 4'd9
  } wreg_e;

  typedef enum logic [3:0] {
    A_C7  = 4'd0,
    A_C5  = 4'd1,
    A_C3  = 4'd2,
    A_C1  = 4'd3,
    A_GXY = 4'd4,
    A_TYB = 4'd5,
    A_TZ  = 4'd6,
    A_GX  = 4'd7,
    A_GY  = 4'd8,
    A_GZ  = 4'd9
  } asel_e;

  typedef enum logic [3:0] {
    B_FX  = 4'd0,
    B_FY  = 4'd1,
    B_FZ  = 4'd2,
    B_XLO = 4'd3,
    B_XHI = 4'd4,
    B_YLO = 4'd5,
    B_YHI = 4'd6,
    B_ZLO = 4'd7,
    B_ZHI = 4'd8
  } bsel_e;

  typedef struct packed {
    asel_e             a_sel;
    bsel_e             b_sel;
    logic              shift;
    logic [N_WREG-1:0] dst;
  } uop_t;

  typedef struct packed {
    logic                 accept;
    logic                 ram_wr;
    logic                 loc_mul;
    logic                 loc_chk;
    axis_e                axis;
    logic                 addr;
    logic                 rd_en;
    logic [2:0]           corner;
    logic                 init;
    logic                 uop_en;
    logic [UOP_IDX_W-1:0] uop_idx;
    logic                 load_out;
  } tti_cmd_t;

  typedef struct packed {
    logic oor;
    logic out_busy;
  } tti_stat_t;

  // Coefficient register c[m] sums the corners b inside mask m with sign
  // (-1)^popcount(m^b). Each step multiplies one operand by a fraction or a
  // reciprocal half and adds the result into the marked registers.
  function automatic uop_t uop_rom(input logic [UOP_IDX_W-1:0] idx);
    uop_t u;
    u.a_sel = A_C7;
    u.b_sel = B_FX;
    u.shift = 1'b1;
    u.dst   = '0;
    case (idx)
      5'd0: begin u.a_sel = A_C7;  u.b_sel = B_FZ; u.dst[W_GXY] = 1'b1; end
      5'd1: begin u.a_sel = A_C7;  u.b_sel = B_FY; u.dst[W_TYB] = 1'b1; end
      5'd2: begin u.a_sel = A_C5;  u.b_sel = B_FZ; u.dst[W_GX]  = 1'b1; end
      5'd3: begin
        u.a_sel = A_C3;  u.b_sel = B_FZ; u.dst[W_GY] = 1'b1; u.dst[W_TZ] = 1'b1;
      end
      5'd4: begin u.a_sel = A_C3;  u.b_sel = B_FY; u.dst[W_GZ]  = 1'b1; end
      5'd5: begin u.a_sel = A_C1;  u.b_sel = B_FZ; u.dst[W_VAL] = 1'b1; end
      5'd6: begin u.a_sel = A_GXY; u.b_sel = B_FY; u.dst[W_GX]  = 1'b1; end
      5'd7: begin u.a_sel = A_GXY; u.b_sel = B_FX; u.dst[W_GY]  = 1'b1; end
      5'd8: begin u.a_sel = A_TYB; u.b_sel = B_FX; u.dst[W_GZ]  = 1'b1; end
      5'd9: begin u.a_sel = A_TZ;  u.b_sel = B_FY; u.dst[W_VAL] = 1'b1; end
      5'd10: begin u.a_sel = A_GX; u.b_sel = B_FX; u.dst[W_VAL] = 1'b1; end
      5'd11: begin u.a_sel = A_GX; u.b_sel = B_XLO; u.dst[W_SX] = 1'b1; end
      5'd12: begin
        u.a_sel = A_GX; u.b_sel = B_XHI; u.shift = 1'b0; u.dst[W_SX] = 1'b1;
      end
      5'd13: begin u.a_sel = A_GY; u.b_sel = B_YLO; u.dst[W_SY] = 1'b1; end
      5'd14: begin
        u.a_sel = A_GY; u.b_sel = B_YHI; u.shift = 1'b0; u.dst[W_SY] = 1'b1;
      end
      5'd15: begin u.a_sel = A_GZ; u.b_sel = B_ZLO; u.dst[W_SZ] = 1'b1; end
      5'd16: begin
        u.a_sel = A_GZ; u.b_sel = B_ZHI; u.shift = 1'b0; u.dst[W_SZ] = 1'b1;
      end
      default: u.dst = '0;
    endcase
    return u;
  endfunction

  function automatic logic [OUT_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic [OUT_W-1:0] r;
    if ((&v[ACC_W-1:OUT_W-1]) || !(|v[ACC_W-1:OUT_W-1])) begin
      r = v[OUT_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### hw/rtl/trilinear_table_interpolator_core.sv
// ----------------------------------------------------------------------------
// Trilinear table interpolator core
// Uniform 3D table with trilinear value and gradient queries.
// ----------------------------------------------------------------------------
// The block takes one word at a time. A table write passes through a write
// state and a done state before its result is ready. A query that finds an
// axis outside the grid ends early (the locator stops at the first failing
// axis). A query's length is set by the single-port table, which returns
// the eight corners one after another, and by the shared multiplier that
// runs the seventeen steps of the coefficient chain and the slope scaling.
// A finished result waits in the output register while the next word is
// accepted. The table has no reset; entries must be written before a query
// reads them.
`include "trilinear_table_interpolator_core_defines.svh"

module trilinear_table_interpolator_core #(
  parameter int unsigned GRID_X = 16,
  parameter int unsigned GRID_Y = 16,
  parameter int unsigned GRID_Z = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tti_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [tti_pkg::DATA_W-1:0]            cfg_data_i,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // entry_index, entry_value, query_x, query_y, query_z, zero pad
  input  logic [tti_pkg::IN_TDATA_W-1:0]        s_axis_tdata_i,
  // operation
  input  logic                                  s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // interp_value, slope_x, slope_y, slope_z
  output logic [tti_pkg::OUT_TDATA_W-1:0]       m_axis_tdata_o,
  // status
  output logic [1:0]                            m_axis_tuser_o
);

  tti_pkg::tti_cmd_t  cmd;
  tti_pkg::tti_stat_t stat;

  tti_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_op_i    (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tti_datapath #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata_i),
    .in_op_i      (s_axis_tuser_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o)
  );

  // An out-of-range query and a write carry all-zero results.
  `TTI_ASSERT(a_oor_zero, (m_axis_tvalid_o && (m_axis_tuser_o != tti_pkg::ST_OK)) |-> (m_axis_tdata_o == '0), "out-of-range result carries data")
  // A result is never loaded in the cycle right after a word is accepted.
  `TTI_ASSERT(a_no_early_load, (s_axis_tvalid_i && s_axis_tready_o) |=> !cmd.load_out, "result loaded too early")
  // The single table port never reads and writes together.
  `TTI_ASSERT_NEVER(a_port_conflict, cmd.ram_wr && cmd.rd_en, "table read and write collide")

endmodule

### hw/rtl/tti_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module tti_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tti_ctrl.sv
// ----------------------------------------------------------------------------
// Trilinear table interpolator controller
// One word at a time: write, or locate, corner reads, multiply chain; output.
// ----------------------------------------------------------------------------
module tti_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_ready_o,
  input  tti_pkg::tti_stat_t  stat_i,
  output tti_pkg::tti_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WR,
    S_MUL,
    S_CHK,
    S_ADDR,
    S_READ,
    S_DRAIN,
    S_INIT,
    S_UOP,
    S_UDRAIN,
    S_DONE
  } state_e;

  state_e                        state_q, state_d;
  tti_pkg::axis_e                axis_q, axis_d;
  logic [tti_pkg::UOP_IDX_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.axis    = axis_q;
    cmd_o.corner  = cnt_q[2:0];
    cmd_o.uop_idx = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          axis_d       = tti_pkg::AX_X;
          state_d      = (in_op_i == tti_pkg::OP_QUERY) ? S_MUL : S_WR;
        end
      end
      S_WR: begin
        cmd_o.ram_wr = 1'b1;
        state_d      = S_DONE;
      end
      S_MUL: begin
        cmd_o.loc_mul = 1'b1;
        state_d       = S_CHK;
      end
      S_CHK: begin
        cmd_o.loc_chk = 1'b1;
        if (stat_i.oor) begin
          state_d = S_DONE;
        end else if (axis_q == tti_pkg::AX_Z) begin
          state_d = S_ADDR;
        end else begin
          axis_d  = tti_pkg::axis_e'(axis_q + 2'd1);
          state_d = S_MUL;
        end
      end
      S_ADDR: begin
        cmd_o.addr = 1'b1;
        cnt_d      = '0;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q[2:0] == 3'd7) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: state_d = S_INIT;
      S_INIT: begin
        cmd_o.init = 1'b1;
        cnt_d      = '0;
        state_d    = S_UOP;
      end
      S_UOP: begin
        cmd_o.uop_en = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == tti_pkg::UOP_IDX_W'(tti_pkg::N_UOP - 1)) begin
          state_d = S_UDRAIN;
        end
      end
      S_UDRAIN: state_d = S_DONE;
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= tti_pkg::AX_X;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

### hw/rtl/tti_datapath.sv
// ----------------------------------------------------------------------------
// Trilinear table interpolator datapath
// Configuration registers, cell locator, grid table, coefficient
// accumulators, shared multiply-accumulate unit and output register.
// ----------------------------------------------------------------------------
module tti_datapath #(
  parameter int unsigned GRID_X = 16,
  parameter int unsigned GRID_Y = 16,
  parameter int unsigned GRID_Z = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tti_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tti_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic [tti_pkg::IN_TDATA_W-1:0]    in_data_i,
  input  logic                              in_op_i,
  input  tti_pkg::tti_cmd_t                 cmd_i,
  output tti_pkg::tti_stat_t                stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tti_pkg::OUT_TDATA_W-1:0]   out_data_o,
  output logic [1:0]                        out_status_o
);

  localparam int unsigned XW  = (GRID_X > 2) ? $clog2(GRID_X) : 1;
  localparam int unsigned YW  = (GRID_Y > 2) ? $clog2(GRID_Y) : 1;
  localparam int unsigned ZW  = (GRID_Z > 2) ? $clog2(GRID_Z) : 1;
  localparam int unsigned AW  = tti_pkg::STORE_AW;
  localparam int unsigned DW  = tti_pkg::DATA_W;
  localparam int unsigned PW  = tti_pkg::MOP_W + tti_pkg::FRAC_W;
  localparam logic [AW-1:0] STRIDE_X = AW'((GRID_Y * GRID_Z) % tti_pkg::STORE_DEPTH);
  localparam logic [AW-1:0] STRIDE_Y = AW'(GRID_Z % tti_pkg::STORE_DEPTH);

  // Configuration registers.
  logic [DW-1:0] org_q [3];
  logic [DW-1:0] inv_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        inv_q[i] <= tti_pkg::INV_STEP_RESET;
      end
    end else if (cfg_we_i) begin
      case (tti_pkg::cfg_e'(cfg_index_i))
        tti_pkg::CFG_ORIGIN_X:   org_q[0] <= cfg_data_i;
        tti_pkg::CFG_ORIGIN_Y:   org_q[1] <= cfg_data_i;
        tti_pkg::CFG_ORIGIN_Z:   org_q[2] <= cfg_data_i;
        tti_pkg::CFG_INV_STEP_X: inv_q[0] <= cfg_data_i;
        tti_pkg::CFG_INV_STEP_Y: inv_q[1] <= cfg_data_i;
        tti_pkg::CFG_INV_STEP_Z: inv_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input word.
  logic [AW-1:0] idx_q;
  logic [DW-1:0] value_q;
  logic [DW-1:0] qry_q [3];
  logic          is_query_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q      <= in_data_i[11:0];
      value_q    <= in_data_i[43:12];
      qry_q[0]   <= in_data_i[75:44];
      qry_q[1]   <= in_data_i[107:76];
      qry_q[2]   <= in_data_i[139:108];
      is_query_q <= (in_op_i == tti_pkg::OP_QUERY);
    end
  end

  // Cell locator, one axis at a time.
  logic [DW-1:0]        q_sel, org_sel, inv_sel, lim_sel;
  logic signed [33:0]   dn;
  logic [64:0]          loc_prod;
  logic [63:0]          mag_q;
  logic                 neg_q;
  logic signed [33:0]   frac_full;
  logic [tti_pkg::FRAC_W-1:0] frac_new;
  logic                 oor;

  always_comb begin
    case (cmd_i.axis)
      tti_pkg::AX_X: begin
        q_sel = qry_q[0]; org_sel = org_q[0]; inv_sel = inv_q[0]; lim_sel = DW'(GRID_X - 1);
      end
      tti_pkg::AX_Y: begin
        q_sel = qry_q[1]; org_sel = org_q[1]; inv_sel = inv_q[1]; lim_sel = DW'(GRID_Y - 1);
      end
      tti_pkg::AX_Z: begin
        q_sel = qry_q[2]; org_sel = org_q[2]; inv_sel = inv_q[2]; lim_sel = DW'(GRID_Z - 1);
      end
      default: begin
        q_sel = qry_q[0]; org_sel = org_q[0]; inv_sel = inv_q[0]; lim_sel = DW'(GRID_X - 1);
      end
    endcase
  end

  assign dn       = $signed({{2{q_sel[DW-1]}}, q_sel}) - $signed({{2{org_sel[DW-1]}}, org_sel})
                  + 34'sd1;
  assign loc_prod = dn[32:0] * inv_sel;

  // A point below origin minus one LSB only stays inside when the reciprocal is zero.
  assign oor       = neg_q ? (inv_sel != '0) : (mag_q[63:32] >= lim_sel);
  assign frac_full = $signed({2'b00, mag_q[31:0]}) - $signed({2'b00, inv_sel});
  assign frac_new  = frac_full[32:16];

  logic [XW-1:0] cx_q;
  logic [YW-1:0] cy_q;
  logic [ZW-1:0] cz_q;
  logic signed [tti_pkg::FRAC_W-1:0] fx_q, fy_q, fz_q;
  tti_pkg::status_e status_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.loc_mul) begin
      mag_q <= dn[33] ? 64'd0 : loc_prod[63:0];
      neg_q <= dn[33];
    end
    if (cmd_i.loc_chk && !oor) begin
      case (cmd_i.axis)
        tti_pkg::AX_X: begin cx_q <= mag_q[32 +: XW]; fx_q <= frac_new; end
        tti_pkg::AX_Y: begin cy_q <= mag_q[32 +: YW]; fy_q <= frac_new; end
        tti_pkg::AX_Z: begin cz_q <= mag_q[32 +: ZW]; fz_q <= frac_new; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= tti_pkg::ST_OK;
    end else if (cmd_i.accept) begin
      status_q <= tti_pkg::ST_OK;
    end else if (cmd_i.loc_chk && oor) begin
      case (cmd_i.axis)
        tti_pkg::AX_X: status_q <= tti_pkg::ST_X_OUT;
        tti_pkg::AX_Y: status_q <= tti_pkg::ST_Y_OUT;
        tti_pkg::AX_Z: status_q <= tti_pkg::ST_Z_OUT;
        default:       status_q <= tti_pkg::ST_X_OUT;
      endcase
    end
  end

  // Corner addressing; flat indices wrap at the table depth.
  logic [XW+AW-1:0] bx;
  logic [YW+AW-1:0] by;
  logic [AW-1:0]    base_q, off, rd_addr, ram_addr;
  logic [DW-1:0]    rdata;

  assign bx = cx_q * STRIDE_X;
  assign by = cy_q * STRIDE_Y;

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr) begin
      base_q <= bx[AW-1:0] + by[AW-1:0] + AW'(cz_q);
    end
  end

  assign off      = (cmd_i.corner[2] ? STRIDE_X : '0) + (cmd_i.corner[1] ? STRIDE_Y : '0)
                  + AW'(cmd_i.corner[0]);
  assign rd_addr  = base_q + off;
  assign ram_addr = cmd_i.ram_wr ? idx_q : rd_addr;

  tti_ram #(
    .WIDTH (DW),
    .DEPTH (tti_pkg::STORE_DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_wr),
    .addr_i  (ram_addr),
    .wdata_i (value_q),
    .rdata_o (rdata)
  );

  // Coefficient accumulators, filled as corner words return.
  logic                              acc_vld_q;
  logic [2:0]                        acc_b_q;
  logic signed [tti_pkg::COEF_W-1:0] c_q [8];
  logic signed [tti_pkg::COEF_W-1:0] rval;

  assign rval = tti_pkg::COEF_W'($signed(rdata));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
      acc_b_q   <= '0;
    end else begin
      acc_vld_q <= cmd_i.rd_en;
      acc_b_q   <= cmd_i.corner;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int m = 0; m < 8; m++) begin
      if (cmd_i.addr) begin
        c_q[m] <= '0;
      end else if (acc_vld_q && ((acc_b_q & ~3'(m)) == 3'd0)) begin
        if (^(acc_b_q ^ 3'(m))) begin
          c_q[m] <= c_q[m] - rval;
        end else begin
          c_q[m] <= c_q[m] + rval;
        end
      end
    end
  end

  // Shared multiply-accumulate unit: product registered, added next cycle.
  tti_pkg::uop_t                          uop;
  logic signed [tti_pkg::MOP_W-1:0]       a_op;
  logic signed [tti_pkg::FRAC_W-1:0]      b_op;
  logic signed [PW-1:0]                   mprod, prod_q;
  logic                                   sh_q;
  logic [tti_pkg::N_WREG-1:0]             dst_q;
  logic signed [tti_pkg::ACC_W-1:0]       addend;
  logic signed [tti_pkg::ACC_W-1:0]       w_q [tti_pkg::N_WREG];

  assign uop = tti_pkg::uop_rom(cmd_i.uop_idx);

  always_comb begin
    case (uop.a_sel)
      tti_pkg::A_C7:  a_op = tti_pkg::MOP_W'(c_q[7]);
      tti_pkg::A_C5:  a_op = tti_pkg::MOP_W'(c_q[5]);
      tti_pkg::A_C3:  a_op = tti_pkg::MOP_W'(c_q[3]);
      tti_pkg::A_C1:  a_op = tti_pkg::MOP_W'(c_q[1]);
      tti_pkg::A_GXY: a_op = w_q[tti_pkg::W_GXY][tti_pkg::MOP_W-1:0];
      tti_pkg::A_TYB: a_op = w_q[tti_pkg::W_TYB][tti_pkg::MOP_W-1:0];
      tti_pkg::A_TZ:  a_op = w_q[tti_pkg::W_TZ][tti_pkg::MOP_W-1:0];
      tti_pkg::A_GX:  a_op = w_q[tti_pkg::W_GX][tti_pkg::MOP_W-1:0];
      tti_pkg::A_GY:  a_op = w_q[tti_pkg::W_GY][tti_pkg::MOP_W-1:0];
      tti_pkg::A_GZ:  a_op = w_q[tti_pkg::W_GZ][tti_pkg::MOP_W-1:0];
      default:        a_op = '0;
    endcase
    case (uop.b_sel)
      tti_pkg::B_FX:  b_op = fx_q;
      tti_pkg::B_FY:  b_op = fy_q;
      tti_pkg::B_FZ:  b_op = fz_q;
      tti_pkg::B_XLO: b_op = $signed({1'b0, inv_q[0][15:0]});
      tti_pkg::B_XHI: b_op = $signed({1'b0, inv_q[0][31:16]});
      tti_pkg::B_YLO: b_op = $signed({1'b0, inv_q[1][15:0]});
      tti_pkg::B_YHI: b_op = $signed({1'b0, inv_q[1][31:16]});
      tti_pkg::B_ZLO: b_op = $signed({1'b0, inv_q[2][15:0]});
      tti_pkg::B_ZHI: b_op = $signed({1'b0, inv_q[2][31:16]});
      default:        b_op = '0;
    endcase
  end

  assign mprod  = a_op * b_op;
  assign addend = sh_q ? tti_pkg::ACC_W'(prod_q >>> 16) : tti_pkg::ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_q <= '0;
      sh_q  <= 1'b0;
    end else begin
      dst_q <= cmd_i.uop_en ? uop.dst : '0;
      sh_q  <= uop.shift;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mprod;
    if (cmd_i.init) begin
      w_q[tti_pkg::W_GXY] <= tti_pkg::ACC_W'(c_q[6]);
      w_q[tti_pkg::W_TYB] <= tti_pkg::ACC_W'(c_q[5]);
      w_q[tti_pkg::W_GX]  <= tti_pkg::ACC_W'(c_q[4]);
      w_q[tti_pkg::W_GY]  <= tti_pkg::ACC_W'(c_q[2]);
      w_q[tti_pkg::W_GZ]  <= tti_pkg::ACC_W'(c_q[1]);
      w_q[tti_pkg::W_TZ]  <= tti_pkg::ACC_W'(c_q[2]);
      w_q[tti_pkg::W_VAL] <= tti_pkg::ACC_W'(c_q[0]);
      w_q[tti_pkg::W_SX]  <= '0;
      w_q[tti_pkg::W_SY]  <= '0;
      w_q[tti_pkg::W_SZ]  <= '0;
    end else begin
      for (int i = 0; i < tti_pkg::N_WREG; i++) begin
        if (dst_q[i]) begin
          w_q[i] <= w_q[i] + addend;
        end
      end
    end
  end

  // Output register.
  logic                             out_valid_q;
  logic [tti_pkg::OUT_TDATA_W-1:0]  out_data_q;
  logic [1:0]                       out_status_q;
  logic                             zero_res;

  assign zero_res = (status_q != tti_pkg::ST_OK) || !is_query_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      if (zero_res) begin
        out_data_q <= '0;
      end else begin
        out_data_q <= {tti_pkg::sat48(w_q[tti_pkg::W_SZ]), tti_pkg::sat48(w_q[tti_pkg::W_SY]),
                       tti_pkg::sat48(w_q[tti_pkg::W_SX]), tti_pkg::sat48(w_q[tti_pkg::W_VAL])};
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;
  assign out_status_o    = out_status_q;
  assign stat_o.oor      = oor;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

endmodule
